@@ rtl/fvn_pkg.sv @@
// ----------------------------------------------------------------------------
// fvn_pkg
// shared constants, types and the cosine weight function of the noise block
// ----------------------------------------------------------------------------
package fvn_pkg;

  localparam int OCTAVES_DEF   = 6;
  localparam int FRAC_BITS_DEF = 8;

  localparam int SEED_W  = 32;
  localparam int LEVEL_W = 4;
  localparam int WORLD_W = 16;
  localparam int POS_W   = 24;
  localparam int OUT_W   = 19;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 2;

  // coordinate widths: 14 doublings at most, then up to 7 octave shifts
  localparam int XW = POS_W + 14;
  localparam int CW = XW + 7;

  localparam int LEVEL_SHIFT = 14;
  localparam int SH_W        = 5;
  localparam int W_W         = 17;
  localparam int V_W         = 18;
  localparam int LAT_W       = 32;

  localparam logic signed [OUT_W-1:0] OUT_MIN = -19'sd262144;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 19'sd262143;

  typedef enum logic [IDX_W-1:0] {
    REG_SEED   = 2'd0,
    REG_LEVELS = 2'd1,
    REG_WORLD  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [SH_W-1:0] sh;
    logic            last;
    logic            zero;
    logic [W_W-1:0]  wx;
    logic [W_W-1:0]  wy;
  } meta_t;

  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint PI_Q30  = 64'sd3373259426;

  function automatic longint half_weight(longint idx, int fb);
    longint u;
    longint u2;
    longint p;
    longint c;
    longint f;
    u  = (PI_Q30 * idx) >>> fb;
    u2 = (u * u) >>> 30;
    p  = Q30_ONE - u2 / 132;
    p  = Q30_ONE - ((u2 * p) >>> 30) / 90;
    p  = Q30_ONE - ((u2 * p) >>> 30) / 56;
    p  = Q30_ONE - ((u2 * p) >>> 30) / 30;
    p  = Q30_ONE - ((u2 * p) >>> 30) / 12;
    c  = Q30_ONE - ((u2 * p) >>> 30) / 2;
    f  = (Q30_ONE - c) / 2;
    return (f + 64'sd8192) >>> 14;
  endfunction

  function automatic longint cos_weight(longint idx, int fb);
    longint full;
    full = 64'sd1 <<< fb;
    if (2 * idx > full) begin
      return 64'sd65536 - half_weight(full - idx, fb);
    end
    return half_weight(idx, fb);
  endfunction

endpackage

@@ rtl/fractal_value_noise_2d.sv @@
// ----------------------------------------------------------------------------
// fractal_value_noise_2d
// fractal 2d value noise: smoothed lattice hash, cosine blend, octave and
// level sums, one q3.16 result per q16.8 map point
// ----------------------------------------------------------------------------
// channel  | handshake            | payload
// in       | in_valid_i/in_stall_o | x_pos_i, y_pos_i
// out      | out_valid_o/out_stall_i | noise_value_o
// cfg      | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// one octave evaluation enters the pipeline per cycle while the output is
// not stalled, so an item issues fractal_levels * OCTAVES evaluations, a
// single one when fractal_levels is zero; the next item is taken while the
// last evaluation of the previous one issues.
// reset clears control and the registers to their defaults. a stalled
// output freezes the whole pipeline.
// ----------------------------------------------------------------------------
module fractal_value_noise_2d #(
  parameter int OCTAVES   = fvn_pkg::OCTAVES_DEF,
  parameter int FRAC_BITS = fvn_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [fvn_pkg::POS_W-1:0]           x_pos_i,
  input  logic [fvn_pkg::POS_W-1:0]           y_pos_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [fvn_pkg::OUT_W-1:0]    noise_value_o,
  input  logic                                cfg_we_i,
  input  logic [fvn_pkg::IDX_W-1:0]           cfg_idx_i,
  input  logic [fvn_pkg::CFG_W-1:0]           cfg_data_i
);
  import fvn_pkg::*;

  localparam int OCT_W   = (OCTAVES > 1) ? $clog2(OCTAVES) : 1;
  localparam int SHIFT   = 2 * (OCTAVES - 1) + LEVEL_SHIFT;
  localparam int ACC_W   = 2 * OCTAVES + 34;
  localparam int NSTAGE  = 10;
  localparam int FULL    = 1 << FRAC_BITS;

  // configuration
  logic [SEED_W-1:0]  seed_q;
  logic [LEVEL_W-1:0] levels_q;
  logic [WORLD_W-1:0] world_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= '0;
      levels_q <= LEVEL_W'(4);
      world_q  <= WORLD_W'(256);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SEED:   seed_q   <= cfg_data_i[SEED_W-1:0];
        REG_LEVELS: levels_q <= cfg_data_i[LEVEL_W-1:0];
        REG_WORLD:  world_q  <= cfg_data_i[WORLD_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic en;
  logic out_valid_q;
  logic [NSTAGE-1:0] vld_q;
  meta_t             meta_q [NSTAGE];

  assign en = !(out_valid_q && out_stall_i);

  // sequencer
  logic             busy_q;
  logic [LEVEL_W-1:0] lvl_q;
  logic [OCT_W-1:0] oct_q;
  logic [XW-1:0]    x_q, y_q;
  logic             lvl_last, zero_lvl, last_iss, in_acc;
  logic [XW:0]      x2, y2;
  logic [XW:0]      lim;
  logic [SH_W-1:0]  sh_d;

  assign zero_lvl = (levels_q == '0);
  assign lvl_last = zero_lvl || (lvl_q == levels_q - LEVEL_W'(1));
  assign last_iss = zero_lvl || ((oct_q == OCT_W'(OCTAVES - 1)) && lvl_last);
  assign in_stall_o = !en || (busy_q && !last_iss);
  assign in_acc = in_valid_i && !in_stall_o;
  assign lim = (XW+1)'({world_q, 8'h00});
  assign x2 = {x_q, 1'b0};
  assign y2 = {y_q, 1'b0};
  assign sh_d = SH_W'(2 * (OCTAVES - 1) + LEVEL_SHIFT) - SH_W'({oct_q, 1'b0})
              - SH_W'(lvl_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      lvl_q  <= '0;
      oct_q  <= '0;
    end else if (en) begin
      if (in_acc) begin
        busy_q <= 1'b1;
        lvl_q  <= '0;
        oct_q  <= '0;
      end else if (busy_q) begin
        if (last_iss) begin
          busy_q <= 1'b0;
        end else if (oct_q == OCT_W'(OCTAVES - 1)) begin
          oct_q <= '0;
          lvl_q <= lvl_q + LEVEL_W'(1);
        end else begin
          oct_q <= oct_q + OCT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (in_acc) begin
        x_q <= XW'(x_pos_i);
        y_q <= XW'(y_pos_i);
      end else if (busy_q && !last_iss && (oct_q == OCT_W'(OCTAVES - 1))) begin
        x_q <= (x2 > lim) ? XW'(x2 - lim) : XW'(x2);
        y_q <= (y2 > lim) ? XW'(y2 - lim) : XW'(y2);
      end
    end
  end

  // stage 0: scaled coordinates
  logic [CW-1:0] cx_q, cy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q <= CW'(x_q) << oct_q;
      cy_q <= CW'(y_q) << oct_q;
      meta_q[0].sh   <= sh_d;
      meta_q[0].last <= last_iss;
      meta_q[0].zero <= zero_lvl;
      meta_q[0].wx   <= '0;
      meta_q[0].wy   <= '0;
    end
  end

  // stage a: hash base and cosine weights
  logic [W_W-1:0] wtab [FULL];
  for (genvar g = 0; g < FULL; g++) begin : g_wtab
    assign wtab[g] = W_W'(cos_weight(longint'(g), FRAC_BITS));
  end

  logic [15:0]          fx16, fy16;
  logic [LAT_W-1:0]     base_q;

  assign fx16 = {cx_q[7:0], 8'h00} >> (16 - FRAC_BITS);
  assign fy16 = {cy_q[7:0], 8'h00} >> (16 - FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (en) begin
      base_q <= cx_q[39:8] + cy_q[39:8] * 32'd57 + seed_q;
      meta_q[1].sh   <= meta_q[0].sh;
      meta_q[1].last <= meta_q[0].last;
      meta_q[1].zero <= meta_q[0].zero;
      meta_q[1].wx   <= wtab[fx16[FRAC_BITS-1:0]];
      meta_q[1].wy   <= wtab[fy16[FRAC_BITS-1:0]];
    end
  end

  // stages b..e: sixteen lattice hashes over the 4x4 neighborhood
  logic signed [LAT_W-1:0] lat [16];
  for (genvar j = 0; j < 16; j++) begin : g_hash
    localparam int OFF = (j % 4 - 1) + 57 * (j / 4 - 1);
    fvn_hash u_hash (
      .clk_i (clk_i),
      .en_i  (en),
      .n_i   (base_q + LAT_W'(OFF)),
      .lat_o (lat[j])
    );
  end

  // stage f: 3x3 smoothing of the four cell corners
  logic signed [V_W-1:0] v_d [4];
  logic signed [V_W-1:0] v_q [4];

  always_comb begin
    logic signed [35:0] s;
    int r, c;
    for (int k = 0; k < 4; k++) begin
      r = k / 2;
      c = k % 2;
      s = 36'(lat[r*4+c]) + 36'(lat[r*4+c+2]) + 36'(lat[(r+2)*4+c])
        + 36'(lat[(r+2)*4+c+2])
        + ((36'(lat[(r+1)*4+c]) + 36'(lat[(r+1)*4+c+2]) + 36'(lat[r*4+c+1])
          + 36'(lat[(r+2)*4+c+1])) <<< 1)
        + (36'(lat[(r+1)*4+c+1]) <<< 2);
      v_d[k] = s[35:18];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        v_q[k] <= v_d[k];
      end
    end
  end

  // stage g: horizontal blend products
  logic signed [V_W-1:0] va_q, vc_q;
  logic signed [36:0]    pa_q, pb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      va_q <= v_q[0];
      vc_q <= v_q[2];
      pa_q <= 37'((19'(v_q[1]) - 19'(v_q[0])) * $signed({1'b0, meta_q[6].wx}));
      pb_q <= 37'((19'(v_q[3]) - 19'(v_q[2])) * $signed({1'b0, meta_q[6].wx}));
    end
  end

  // stage h: vertical blend product
  logic signed [V_W-1:0] r1_d, r2_d, r1_q;
  logic signed [36:0]    pc_q;

  assign r1_d = V_W'(19'(va_q) + 19'(pa_q >>> 16));
  assign r2_d = V_W'(19'(vc_q) + 19'(pb_q >>> 16));

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_q <= r1_d;
      pc_q <= 37'((19'(r2_d) - 19'(r1_d)) * $signed({1'b0, meta_q[7].wy}));
    end
  end

  // stage i: weighted octave term
  logic signed [V_W-1:0]   vi_d;
  logic signed [ACC_W-1:0] term_q;

  assign vi_d = V_W'(19'(r1_q) + 19'(pc_q >>> 16));

  always_ff @(posedge clk_i) begin
    if (en) begin
      term_q <= meta_q[8].zero ? '0 : (ACC_W'(vi_d) <<< meta_q[8].sh);
    end
  end

  for (genvar i = 2; i < NSTAGE; i++) begin : g_meta
    always_ff @(posedge clk_i) begin
      if (en) begin
        meta_q[i] <= meta_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTAGE-2:0], busy_q};
    end
  end

  // accumulation and output register
  logic signed [ACC_W-1:0] acc_q, sum_d, red_d;
  logic signed [OUT_W-1:0] out_q, sat_d;

  assign sum_d = acc_q + term_q;
  assign red_d = sum_d >>> SHIFT;

  always_comb begin
    if (red_d < ACC_W'(OUT_MIN)) begin
      sat_d = OUT_MIN;
    end else if (red_d > ACC_W'(OUT_MAX)) begin
      sat_d = OUT_MAX;
    end else begin
      sat_d = red_d[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[NSTAGE-1] && meta_q[NSTAGE-1].last;
      if (vld_q[NSTAGE-1]) begin
        acc_q <= meta_q[NSTAGE-1].last ? '0 : sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vld_q[NSTAGE-1] && meta_q[NSTAGE-1].last) begin
      out_q <= sat_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign noise_value_o = out_q;

endmodule

@@ rtl/fvn_hash.sv @@
// ----------------------------------------------------------------------------
// fvn_hash
// four-stage pipelined 32-bit lattice hash, value 2^30 - m in Q.30
// ----------------------------------------------------------------------------
module fvn_hash (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [fvn_pkg::LAT_W-1:0]          n_i,
  output logic signed [fvn_pkg::LAT_W-1:0]   lat_o
);
  import fvn_pkg::*;

  logic [LAT_W-1:0]        n1_q, n2_q, n3_q;
  logic [LAT_W-1:0]        sq_q, t_q;
  logic [LAT_W-1:0]        m_d;
  logic signed [LAT_W-1:0] lat_q;

  assign m_d = (n3_q * t_q + 32'd1376312589) & 32'h7fffffff;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n1_q  <= n_i ^ (n_i << 13);
      n2_q  <= n1_q;
      sq_q  <= n1_q * n1_q;
      n3_q  <= n2_q;
      t_q   <= sq_q * 32'd15731 + 32'd789221;
      lat_q <= $signed(32'h40000000 - m_d);
    end
  end

  assign lat_o = lat_q;

endmodule

@@ bench/tb_fractal_value_noise_2d.sv @@
// ----------------------------------------------------------------------------
// tb_fractal_value_noise_2d
// self-checking bench for the fractal value noise block: a bit-exact
// predictor of the hash, smoothing, cosine blend and octave/level sums
// checks every result. directed corner points, register sweeps, random
// points with random gaps and output stalls, plus long back-pressure.
// ----------------------------------------------------------------------------
module tb_fractal_value_noise_2d;
  timeunit 1ns;
  timeprecision 1ps;

  import fvn_pkg::*;

  localparam int     NOCT       = OCTAVES_DEF;
  localparam int     FB         = FRAC_BITS_DEF;
  localparam longint CYCLE_LIMIT = 1000000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [POS_W-1:0]        x_pos_i = '0;
  logic [POS_W-1:0]        y_pos_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [OUT_W-1:0] noise_value_o;
  logic                    cfg_we_i = 1'b0;
  logic [IDX_W-1:0]        cfg_idx_i = '0;
  logic [CFG_W-1:0]        cfg_data_i = '0;

  fractal_value_noise_2d u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the registers
  bit [31:0] seed_q   = 32'd0;
  bit [3:0]  levels_q = 4'd4;
  bit [15:0] world_q  = 16'd256;

  logic signed [OUT_W-1:0] noise_exp_q[$];
  int  fail_cnt;
  int  sent_cnt;
  int  recv_cnt;
  int  stall_pct;
  bit  gaps_on;
  int  hold_len;
  int  hold_tok;
  int  hold_tok_seen;
  int  hold_left;
  longint cycle_cnt;

  function automatic longint lattice_hash(bit [31:0] ix, bit [31:0] iy);
    bit [31:0] n;
    bit [31:0] m;
    n = ix + iy * 32'd57 + seed_q;
    n = (n << 13) ^ n;
    m = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
    return (64'sd1 <<< 30) - longint'({32'd0, m});
  endfunction

  function automatic longint smoothed(bit [31:0] ix, bit [31:0] iy);
    longint corners;
    longint sides;
    corners = lattice_hash(ix - 1, iy - 1) + lattice_hash(ix + 1, iy - 1)
            + lattice_hash(ix - 1, iy + 1) + lattice_hash(ix + 1, iy + 1);
    sides   = lattice_hash(ix - 1, iy) + lattice_hash(ix + 1, iy)
            + lattice_hash(ix, iy - 1) + lattice_hash(ix, iy + 1);
    return (corners + 2 * sides + 4 * lattice_hash(ix, iy)) >>> 18;
  endfunction

  function automatic longint rising_weight(longint idx);
    longint unsigned u;
    longint one;
    longint u2;
    longint p;
    longint c;
    one = 64'sd1 <<< 30;
    u   = (64'd3373259426 * longint'(idx)) >> FB;
    u2  = longint'((u * u) >> 30);
    p   = one - u2 / 132;
    p   = one - (u2 * p / one) / 90;
    p   = one - (u2 * p / one) / 56;
    p   = one - (u2 * p / one) / 30;
    p   = one - (u2 * p / one) / 12;
    c   = one - (u2 * p / one) / 2;
    return ((one - c) / 2 + 64'sd8192) >>> 14;
  endfunction

  function automatic longint blend_weight(longint idx);
    longint full;
    full = 64'sd1 <<< FB;
    if (2 * idx > full) begin
      return 64'sd65536 - rising_weight(full - idx);
    end
    return rising_weight(idx);
  endfunction

  function automatic longint lerp(longint a, longint b, longint w);
    return a + (((b - a) * w) >>> 16);
  endfunction

  function automatic longint lattice_point(bit [63:0] cx, bit [63:0] cy);
    bit [31:0] ix;
    bit [31:0] iy;
    longint wx;
    longint wy;
    ix = 32'(cx >> 8);
    iy = 32'(cy >> 8);
    wx = blend_weight(longint'(((cx & 64'hff) << 8) >> (16 - FB)));
    wy = blend_weight(longint'(((cy & 64'hff) << 8) >> (16 - FB)));
    return lerp(lerp(smoothed(ix, iy), smoothed(ix + 1, iy), wx),
                lerp(smoothed(ix, iy + 1), smoothed(ix + 1, iy + 1), wx), wy);
  endfunction

  function automatic logic signed [OUT_W-1:0] fractal_noise(bit [23:0] xp, bit [23:0] yp);
    bit [63:0] x;
    bit [63:0] y;
    bit [63:0] lim;
    longint acc;
    longint oct;
    longint r;
    x   = 64'(xp);
    y   = 64'(yp);
    lim = 64'(world_q) << 8;
    acc = 0;
    for (int k = 0; k < levels_q; k++) begin
      oct = 0;
      for (int i = 0; i < NOCT; i++) begin
        oct += lattice_point(x << i, y << i) * (64'sd1 <<< (2 * (NOCT - 1 - i)));
      end
      acc += oct * (64'sd1 <<< (LEVEL_SHIFT - k));
      x = x * 2;
      y = y * 2;
      if (x > lim) x = x - lim;
      if (y > lim) y = y - lim;
    end
    r = acc >>> (2 * (NOCT - 1) + LEVEL_SHIFT);
    if (r < -262144) r = -262144;
    if (r > 262143) r = 262143;
    return OUT_W'(r);
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stalls, occasional long stretches, requested hold-offs
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_tok != hold_tok_seen) begin
      hold_tok_seen <= hold_tok;
      hold_left     <= hold_len;
      out_stall_i   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(299) == 0) begin
      hold_left   <= $urandom_range(40, 10);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (noise_exp_q.size() == 0) begin
        $error("noise_value: unexpected item, actual %0d", noise_value_o);
        fail_cnt++;
      end else begin
        if (noise_value_o !== noise_exp_q[0]) begin
          $error("noise_value: expected %0d actual %0d", noise_exp_q[0], noise_value_o);
          fail_cnt++;
        end
        void'(noise_exp_q.pop_front());
      end
      recv_cnt++;
    end
  end

  // called at a falling edge; returns at a falling edge, valid still high unless a gap was inserted
  task automatic send_point(bit [23:0] xp, bit [23:0] yp);
    int gap;
    in_valid_i <= 1'b1;
    x_pos_i    <= xp;
    y_pos_i    <= yp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    noise_exp_q.push_back(fractal_noise(xp, yp));
    sent_cnt++;
    @(negedge clk_i);
    gap = 0;
    if (gaps_on) begin
      gap = $urandom_range(99);
      gap = (gap < 60) ? 0 : (gap < 95) ? $urandom_range(3, 1) : $urandom_range(50, 10);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      x_pos_i    <= 24'($urandom);
      y_pos_i    <= 24'($urandom);
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (noise_exp_q.size() != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, bit [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SEED:   seed_q   = data;
      REG_LEVELS: levels_q = data[3:0];
      REG_WORLD:  world_q  = data[15:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  function automatic bit [23:0] rand_pos();
    int lim;
    lim = int'(world_q) << 8;
    if (lim == 0 || $urandom_range(9) == 0) return 24'($urandom);
    return 24'($urandom_range(lim, 0));
  endfunction

  task automatic test_directed();
    bit [23:0] pts[$];
    pts = '{24'h0, 24'hffffff, 24'h000080, 24'h00007f, 24'h000081, 24'h0000ff,
            24'h010000, 24'h00ff80, 24'h000001, 24'h800000, 24'h555555, 24'haaaaaa};
    foreach (pts[i]) send_point(pts[i], pts[pts.size() - 1 - i]);
    send_point(24'hffffff, 24'h0);
    send_point(24'h0, 24'hffffff);
    wait_drained();
  endtask

  task automatic test_register_sweep();
    bit [31:0] seeds[4];
    bit [3:0]  levs[5];
    bit [15:0] worlds[4];
    seeds  = '{32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h0};
    levs   = '{4'd0, 4'd1, 4'd8, 4'd14, 4'd4};
    worlds = '{16'd0, 16'd1, 16'hffff, 16'd256};
    foreach (seeds[i]) begin
      write_reg(REG_SEED, seeds[i]);
      write_reg(REG_LEVELS, 32'(levs[i]));
      write_reg(REG_WORLD, 32'(worlds[i]));
      repeat (5) send_point(rand_pos(), rand_pos());
      send_point(24'hffffff, 24'hffffff);
      wait_drained();
    end
    write_reg(REG_LEVELS, 32'(levs[4]));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) begin
        wait_drained();
        write_reg(REG_SEED, $urandom);
        write_reg(REG_LEVELS, ($urandom_range(9) == 0) ? $urandom_range(14, 9)
                                                        : $urandom_range(5, 1));
        write_reg(REG_WORLD, ($urandom_range(4) == 0) ? $urandom : $urandom_range(512, 1));
        stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(60, 5);
        gaps_on   = ($urandom_range(3) != 0);
      end
      send_point(rand_pos(), rand_pos());
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    gaps_on   = 1'b0;
    stall_pct = 0;
    write_reg(REG_LEVELS, 32'd1);
    hold_len = 400;
    hold_tok++;
    repeat (40) send_point(rand_pos(), rand_pos());
    wait_drained();
  endtask

  task automatic test_sender_pause();
    gaps_on   = 1'b1;
    stall_pct = 30;
    repeat (10) send_point(rand_pos(), rand_pos());
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (noise_exp_q.size() != 0) @(negedge clk_i);
    repeat (10) send_point(rand_pos(), rand_pos());
    wait_drained();
  endtask

  initial begin
    fail_cnt = 0;
    sent_cnt = 0;
    recv_cnt = 0;
    stall_pct = 20;
    gaps_on = 1'b1;
    hold_len = 0;
    hold_tok = 0;
    hold_tok_seen = 0;
    hold_left = 0;
    cycle_cnt = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_register_sweep();
    test_backpressure();
    test_sender_pause();
    test_random(900);
    $display("sent %0d points, checked %0d results over seed, level and world sweeps",
             sent_cnt, recv_cnt);
    $display("with random gaps, output stalls and a long output hold-off");
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
